[design/qrac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrac_pkg: shared types and constants for the quad corner rotator
// Holds the word types of both channels, the pipeline payload, the CORDIC
// start value and the arctangent table in 2^32-per-turn units.
// ----------------------------------------------------------------------------
package qrac_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int TRIG_ITER_DEF  = 16;
	localparam int ATAN_LEN       = 24;

	// trig values are Q2.30 in CW bits, products are PW bits
	localparam int CW = 32;
	localparam int PW = 48;
	localparam int SW = PW + 1;
	localparam int RW = SW - 30;

	localparam logic signed [CW-1:0] CORDIC_START = 32'sd652032874;
	localparam logic signed [SW-1:0] Q30_HALF     = 49'sd536870912;

	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_TR = 2'd1;
	localparam logic [1:0] CORNER_BR = 2'd2;
	localparam logic [1:0] CORNER_BL = 2'd3;

	typedef struct packed {
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic [14:0]        half_width;
		logic [14:0]        half_height;
		logic [15:0]        angle;
		logic [31:0]        color;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic [15:0]        tex_u_span;
		logic [15:0]        tex_v_span;
	} item_t;

	typedef struct packed {
		logic [1:0]         corner;
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic [31:0]        vertex_color;
		logic [15:0]        vertex_u;
		logic [15:0]        vertex_v;
		logic               last;
	} result_t;

	// what rides along with the angle through the CORDIC stages
	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [14:0]        hw;
		logic [14:0]        hh;
		logic [31:0]        color;
		logic [15:0]        u_left;
		logic [15:0]        u_right;
		logic [15:0]        v_top;
		logic [15:0]        v_bottom;
		logic               flip;
	} pay_t;

	function automatic logic signed [CW-1:0] atan_turn(input int idx);
		logic signed [CW-1:0] a;
		case (idx)
			0:  a = 32'sd536870912;
			1:  a = 32'sd316933406;
			2:  a = 32'sd167458907;
			3:  a = 32'sd85004756;
			4:  a = 32'sd42667331;
			5:  a = 32'sd21354465;
			6:  a = 32'sd10679838;
			7:  a = 32'sd5340245;
			8:  a = 32'sd2670163;
			9:  a = 32'sd1335087;
			10: a = 32'sd667544;
			11: a = 32'sd333772;
			12: a = 32'sd166886;
			13: a = 32'sd83443;
			14: a = 32'sd41722;
			15: a = 32'sd20861;
			16: a = 32'sd10430;
			17: a = 32'sd5215;
			18: a = 32'sd2608;
			19: a = 32'sd1304;
			20: a = 32'sd652;
			21: a = 32'sd326;
			22: a = 32'sd163;
			23: a = 32'sd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[design/qrac_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrac_cordic: pipelined rotation-mode CORDIC
// One register stage per iteration; a payload word and a valid bit travel
// with each angle. Outputs cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module qrac_cordic #(
	parameter int ITERATIONS = qrac_pkg::TRIG_ITER_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            vld,
	input  logic signed [qrac_pkg::CW-1:0]  z,
	input  qrac_pkg::pay_t                  pay,
	output logic                            out_vld,
	output logic signed [qrac_pkg::CW-1:0]  cos_val,
	output logic signed [qrac_pkg::CW-1:0]  sin_val,
	output qrac_pkg::pay_t                  out_pay
);
	import qrac_pkg::*;

	logic                 vld_s [1:ITERATIONS];
	logic signed [CW-1:0] x_s   [1:ITERATIONS];
	logic signed [CW-1:0] y_s   [1:ITERATIONS];
	logic signed [CW-1:0] z_s   [1:ITERATIONS];
	pay_t                 pay_s [1:ITERATIONS];

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
		logic                 vi;
		logic signed [CW-1:0] xi;
		logic signed [CW-1:0] yi;
		logic signed [CW-1:0] zi;
		pay_t                 pi;
		logic signed [CW-1:0] xsh;
		logic signed [CW-1:0] ysh;

		if (i == 0) begin : g_entry
			assign vi = vld;
			assign xi = CORDIC_START;
			assign yi = '0;
			assign zi = z;
			assign pi = pay;
		end else begin : g_chain
			assign vi = vld_s[i];
			assign xi = x_s[i];
			assign yi = y_s[i];
			assign zi = z_s[i];
			assign pi = pay_s[i];
		end

		// arithmetic shift floors, as the iteration needs
		assign xsh = xi >>> i;
		assign ysh = yi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			pay_s[i+1] <= pi;
			if (!zi[CW-1]) begin
				x_s[i+1] <= xi - ysh;
				y_s[i+1] <= yi + xsh;
				z_s[i+1] <= zi - atan_turn(i);
			end else begin
				x_s[i+1] <= xi + ysh;
				y_s[i+1] <= yi - xsh;
				z_s[i+1] <= zi + atan_turn(i);
			end
		end
	end

	assign out_vld = vld_s[ITERATIONS];
	assign cos_val = x_s[ITERATIONS];
	assign sin_val = y_s[ITERATIONS];
	assign out_pay = pay_s[ITERATIONS];

endmodule

[design/quad_rotate_about_center_top.sv]
`timescale 1ns / 1ps
// Path: an accepted word runs through stage 1, the CORDIC stages and stages 2 to 4
// before the first vertex strobes; the other three follow back to back.
// The single result port (one vertex a cycle) sets how often a new quad can be taken.
// busy holds off new words after an accept while the port is in use; the receiver cannot stall.
// Reset: arst_n clears all valid bits, the corner sequencer and busy at once.
// ----------------------------------------------------------------------------
// quad_rotate_about_center_top: sprite quad corner rotator
// Rotates the four corner offsets of a quad by the negated angle about its
// center and emits them as vertex words with color and texture corners.
// ----------------------------------------------------------------------------
module quad_rotate_about_center_top #(
	parameter int ANGLE_BITS      = qrac_pkg::ANGLE_BITS_DEF,
	parameter int TRIG_ITERATIONS = qrac_pkg::TRIG_ITER_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  qrac_pkg::item_t   item,
	output logic              result_valid,
	output qrac_pkg::result_t result
);
	import qrac_pkg::*;

	// angle resolution: clear the low bits below ANGLE_BITS
	localparam int          DROP     = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
	localparam logic [15:0] ANG_MASK = ~((16'd1 << DROP) - 16'd1);

	// ---------------------------------------------------------------- accept
	logic [1:0] busy_cnt_q;
	logic       accept;

	assign busy   = (busy_cnt_q != 2'd0);
	assign accept = start & ~busy;

	// hold off new words while the counter runs down: one quad owns the port for all four corners
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= 2'd0;
		end else if (accept) begin
			busy_cnt_q <= 2'd3;
		end else if (busy) begin
			busy_cnt_q <= busy_cnt_q - 2'd1;
		end
	end

	// ---------------------------------------------------------------- stage 1
	// negate the angle into a 32 bit phase, fold the left half-plane by half
	// a turn (flip remembers to negate cos and sin), saturate texture sums
	logic [15:0]          ang_m;
	logic [31:0]          phase;
	logic                 flip;
	logic [16:0]          u_sum;
	logic [16:0]          v_sum;
	pay_t                 pay_in;

	assign ang_m = item.angle & ANG_MASK;
	assign phase = 32'd0 - {ang_m, 16'd0};
	assign flip  = phase[31] ^ phase[30];
	assign u_sum = {1'b0, item.tex_u} + {1'b0, item.tex_u_span};
	assign v_sum = {1'b0, item.tex_v} + {1'b0, item.tex_v_span};

	always_comb begin
		pay_in.cx       = item.center_x;
		pay_in.cy       = item.center_y;
		pay_in.hw       = item.half_width;
		pay_in.hh       = item.half_height;
		pay_in.color    = item.color;
		pay_in.u_left   = item.tex_u;
		pay_in.u_right  = u_sum[16] ? 16'hFFFF : u_sum[15:0];
		pay_in.v_top    = item.tex_v;
		pay_in.v_bottom = v_sum[16] ? 16'hFFFF : v_sum[15:0];
		pay_in.flip     = flip;
	end

	logic                 vld_s1;
	logic signed [CW-1:0] z_s1;
	pay_t                 pay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			z_s1   <= $signed({phase[31] ^ flip, phase[30:0]});
			pay_s1 <= pay_in;
		end
	end

	// ---------------------------------------------------------------- CORDIC
	logic                 cdc_vld;
	logic signed [CW-1:0] cdc_cos;
	logic signed [CW-1:0] cdc_sin;
	pay_t                 cdc_pay;

	qrac_cordic #(
		.ITERATIONS(TRIG_ITERATIONS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld_s1),
		.z       (z_s1),
		.pay     (pay_s1),
		.out_vld (cdc_vld),
		.cos_val (cdc_cos),
		.sin_val (cdc_sin),
		.out_pay (cdc_pay)
	);

	// ---------------------------------------------------------------- stage 2
	// four products once per quad; corners differ only in sign, so hold them
	// while the corner sequencer walks through the four corners
	logic signed [PW-1:0] hwc_s2;
	logic signed [PW-1:0] hhs_s2;
	logic signed [PW-1:0] hhc_s2;
	logic signed [PW-1:0] hws_s2;
	pay_t                 pay_s2;
	logic                 run_q;
	logic [1:0]           corner_q;

	always_ff @(posedge clk) begin
		if (cdc_vld) begin
			hwc_s2 <= $signed({1'b0, cdc_pay.hw}) * cdc_cos;
			hhs_s2 <= $signed({1'b0, cdc_pay.hh}) * cdc_sin;
			hhc_s2 <= $signed({1'b0, cdc_pay.hh}) * cdc_cos;
			hws_s2 <= $signed({1'b0, cdc_pay.hw}) * cdc_sin;
			pay_s2 <= cdc_pay;
		end
	end

	// advance TL, TR, BR, BL; a new quad lands exactly as BL goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			corner_q <= CORNER_TL;
		end else if (cdc_vld) begin
			run_q    <= 1'b1;
			corner_q <= CORNER_TL;
		end else if (run_q) begin
			corner_q <= corner_q + 2'd1;
			if (corner_q == CORNER_BL) begin
				run_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- stage 3
	// pick signs for this corner; flip negates cos and sin, which is the
	// same as negating both offsets, then round half up to Q12.4
	logic                 right;
	logic                 bottom;
	logic                 neg_x;
	logic                 neg_y;
	logic signed [SW-1:0] t_xc;
	logic signed [SW-1:0] t_ys;
	logic signed [SW-1:0] t_yc;
	logic signed [SW-1:0] t_xs;
	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;

	assign right  = (corner_q == CORNER_TR) || (corner_q == CORNER_BR);
	assign bottom = (corner_q == CORNER_BR) || (corner_q == CORNER_BL);
	assign neg_x  = ~right ^ pay_s2.flip;
	assign neg_y  = ~bottom ^ pay_s2.flip;

	always_comb begin
		t_xc  = neg_x ? -{hwc_s2[PW-1], hwc_s2} : {hwc_s2[PW-1], hwc_s2};
		t_ys  = neg_y ? -{hhs_s2[PW-1], hhs_s2} : {hhs_s2[PW-1], hhs_s2};
		t_yc  = neg_y ? -{hhc_s2[PW-1], hhc_s2} : {hhc_s2[PW-1], hhc_s2};
		t_xs  = neg_x ? -{hws_s2[PW-1], hws_s2} : {hws_s2[PW-1], hws_s2};
		sum_x = t_xc - t_ys + Q30_HALF;
		sum_y = t_yc + t_xs + Q30_HALF;
	end

	logic                 vld_s3;
	logic [1:0]           corner_s3;
	logic signed [RW-1:0] rx_s3;
	logic signed [RW-1:0] ry_s3;
	logic signed [15:0]   cx_s3;
	logic signed [15:0]   cy_s3;
	logic [31:0]          color_s3;
	logic [15:0]          u_s3;
	logic [15:0]          v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			corner_s3 <= corner_q;
			rx_s3     <= sum_x[SW-1:30];
			ry_s3     <= sum_y[SW-1:30];
			cx_s3     <= pay_s2.cx;
			cy_s3     <= pay_s2.cy;
			color_s3  <= pay_s2.color;
			u_s3      <= right ? pay_s2.u_right : pay_s2.u_left;
			v_s3      <= bottom ? pay_s2.v_bottom : pay_s2.v_top;
		end
	end

	// ---------------------------------------------------------------- stage 4
	// add the center back and clamp to the signed 16 bit range
	logic signed [RW:0] px;
	logic signed [RW:0] py;
	logic signed [15:0] sx;
	logic signed [15:0] sy;

	always_comb begin
		px = {{(RW - 15){cx_s3[15]}}, cx_s3} + {rx_s3[RW-1], rx_s3};
		py = {{(RW - 15){cy_s3[15]}}, cy_s3} + {ry_s3[RW-1], ry_s3};
		if (px > $signed(20'sd32767)) begin
			sx = 16'sh7FFF;
		end else if (px < $signed(-20'sd32768)) begin
			sx = 16'sh8000;
		end else begin
			sx = px[15:0];
		end
		if (py > $signed(20'sd32767)) begin
			sy = 16'sh7FFF;
		end else if (py < $signed(-20'sd32768)) begin
			sy = 16'sh8000;
		end else begin
			sy = py[15:0];
		end
	end

	logic    vld_s4;
	result_t res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			res_s4.corner       <= corner_s3;
			res_s4.vertex_x     <= sx;
			res_s4.vertex_y     <= sy;
			res_s4.vertex_color <= color_s3;
			res_s4.vertex_u     <= u_s3;
			res_s4.vertex_v     <= v_s3;
			res_s4.last         <= (corner_s3 == CORNER_BL);
		end
	end

	assign result_valid = vld_s4;
	assign result       = res_s4;

endmodule

[design/qrac_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrac_checker: port-level checks for the quad corner rotator
// Watches the command and result ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module qrac_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_valid,
	input qrac_pkg::result_t result
);
	import qrac_pkg::*;

	// an accepted word raises busy and so blocks the words behind it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after an accepted word");

	a_busy_length: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |=> busy ##1 busy ##1 !busy)
		else $error("busy window is not three cycles");

	// corners go out back to back in order
	a_corner_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.corner != CORNER_BL |=>
			result_valid && result.corner == $past(result.corner) + 2'd1)
		else $error("corner sequence broken");

	// all four vertices of one quad carry one color
	a_color_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.corner != CORNER_BL |=> $stable(result.vertex_color))
		else $error("color changed inside a quad");

endmodule

bind quad_rotate_about_center_top qrac_checker u_qrac_checker (.*);
